### rtl/bdhe_pkg.sv
// ---------------------------------------------------------------------------
// bdhe_pkg
// Shared types and constants for the button debounce / hold event block.
// ---------------------------------------------------------------------------
package bdhe_pkg;

  localparam int TICK_W  = 16;
  localparam int COUNT_W = 16;
  localparam int TAG_W   = 8;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 8;
  localparam int CDATA_W = 16;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HELD = 2'd2;

  // input operations
  localparam logic OP_PIN_CHANGE = 1'b0;
  localparam logic OP_TICK       = 1'b1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_INVERT_LEVEL = 8'd0;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 8'd1;
  localparam logic [IDX_W-1:0] REG_HOLD_PERIOD  = 8'd2;
  localparam logic [IDX_W-1:0] REG_SOURCE_TAG   = 8'd3;

  // reset values
  localparam logic [TICK_W-1:0] DEBOUNCE_RESET    = 16'd20;
  localparam logic [TICK_W-1:0] HOLD_PERIOD_RESET = 16'd1000;

  typedef struct packed {
    logic              invert_level;
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] hold_period_ticks;
    logic [TAG_W-1:0]  source_tag;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TAG_W-1:0]   source;
    logic [COUNT_W-1:0] count;
  } evt_t;

endpackage

### rtl/bdhe_cfg.sv
// ---------------------------------------------------------------------------
// bdhe_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
module bdhe_cfg
  import bdhe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_level      <= 1'b0;
      cfg.debounce_ticks    <= DEBOUNCE_RESET;
      cfg.hold_period_ticks <= HOLD_PERIOD_RESET;
      cfg.source_tag        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INVERT_LEVEL: cfg.invert_level      <= cfg_data[0];
        REG_DEBOUNCE:     cfg.debounce_ticks    <= cfg_data[TICK_W-1:0];
        REG_HOLD_PERIOD:  cfg.hold_period_ticks <= cfg_data[TICK_W-1:0];
        REG_SOURCE_TAG:   cfg.source_tag        <= cfg_data[TAG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/bdhe_core.sv
// ---------------------------------------------------------------------------
// bdhe_core
// Debounce and hold-period timer, pressed state and event count; one item per cycle.
// ---------------------------------------------------------------------------
module bdhe_core
  import bdhe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic op,
  input  logic pin_level,
  input  cfg_t cfg,
  output logic emit,
  output evt_t evt
);

  logic               pressed_state, pressed_state_next;
  logic               running, running_next;
  logic [TICK_W-1:0]  ticks_left, ticks_left_next;
  logic [TICK_W-1:0]  reload_ticks, reload_ticks_next;
  logic [COUNT_W-1:0] expiry_count, expiry_count_next;
  logic               pressed;

  assign pressed = (~pin_level) ^ cfg.invert_level;

  always_comb begin
    pressed_state_next = pressed_state;
    running_next       = running;
    ticks_left_next    = ticks_left;
    reload_ticks_next  = reload_ticks;
    expiry_count_next  = expiry_count;
    emit               = 1'b0;
    evt.source         = cfg.source_tag;
    evt.count          = expiry_count;
    if (pressed) begin
      evt.kind = (expiry_count != '0) ? KIND_HELD : KIND_DOWN;
    end else begin
      evt.kind = KIND_UP;
    end

    if (accept) begin
      if (op == OP_PIN_CHANGE) begin
        // restart the debounce countdown
        expiry_count_next = '0;
        reload_ticks_next = cfg.debounce_ticks;
        ticks_left_next   = cfg.debounce_ticks;
        running_next      = 1'b1;
      end else if (running) begin
        if (ticks_left > TICK_W'(1)) begin
          ticks_left_next = ticks_left - TICK_W'(1);
        end else begin
          ticks_left_next = reload_ticks;
          emit            = 1'b1;
          if (expiry_count == '0) begin
            if (pressed == pressed_state) begin
              // level unchanged: stop silently
              running_next = 1'b0;
              emit         = 1'b0;
            end else begin
              pressed_state_next = pressed;
              if (!pressed) begin
                running_next = 1'b0;
              end else begin
                reload_ticks_next = cfg.hold_period_ticks;
                ticks_left_next   = cfg.hold_period_ticks;
              end
            end
          end
          if (emit && (expiry_count != '1)) begin
            expiry_count_next = expiry_count + COUNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_state <= 1'b0;
      running       <= 1'b0;
      ticks_left    <= '0;
      reload_ticks  <= DEBOUNCE_RESET;
      expiry_count  <= '0;
    end else begin
      pressed_state <= pressed_state_next;
      running       <= running_next;
      ticks_left    <= ticks_left_next;
      reload_ticks  <= reload_ticks_next;
      expiry_count  <= expiry_count_next;
    end
  end

endmodule

### rtl/bdhe_out.sv
// ---------------------------------------------------------------------------
// bdhe_out
// Result register; takes a new word whenever it is empty or being drained.
// ---------------------------------------------------------------------------
module bdhe_out
  import bdhe_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  evt_t                         evt,
  output logic                         open,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [TAG_W+COUNT_W-1:0]     m_axis_tdata,
  output logic [KIND_W-1:0]            m_axis_tuser
);

  evt_t held;

  assign open          = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {held.count, held.source};
  assign m_axis_tuser  = held.kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (open) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (open && load) begin
      held <= evt;
    end
  end

endmodule

### rtl/button_debounce_hold_events.sv
// ---------------------------------------------------------------------------
// button_debounce_hold_events
// Debounced button qualifier emitting down, up and held events.
// ---------------------------------------------------------------------------
// Each input word is either a pin change (tuser 0) or a one-millisecond tick
// (tuser 1) carrying the raw pin level in tdata bit 0. Every word is handled
// in the cycle it is accepted, so the block takes one word per clock; the
// only thing that can hold off the input is a finished event still sitting
// in the single output register while the downstream side stalls. Events
// leave with the kind in tuser and the source tag and expiry count in tdata.
// Configuration writes are taken every cycle and should be made while idle.
module button_debounce_hold_events
  import bdhe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CDATA_W-1:0]       cfg_data,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [0] pin_level, [7:1] zero
  input  logic                     s_axis_tuser,  // [0] op
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [TAG_W+COUNT_W-1:0] m_axis_tdata,  // [7:0] event_source, [23:8] event_count
  output logic [KIND_W-1:0]        m_axis_tuser   // [1:0] event_kind
);

  cfg_t cfg;
  evt_t evt;
  logic emit;
  logic accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  bdhe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdhe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (s_axis_tuser),
    .pin_level (s_axis_tdata[0]),
    .cfg       (cfg),
    .emit      (emit),
    .evt       (evt)
  );

  bdhe_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (emit),
    .evt           (evt),
    .open          (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### rtl/bdhe_checker.sv
// ---------------------------------------------------------------------------
// bdhe_checker
// Port-level checks for the button debounce / hold event block.
// ---------------------------------------------------------------------------
module bdhe_checker
  import bdhe_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     s_axis_tuser,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [TAG_W+COUNT_W-1:0] m_axis_tdata,
  input logic [KIND_W-1:0]        m_axis_tuser
);

  // stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // an event is only ever down, up or held
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == KIND_DOWN || m_axis_tuser == KIND_UP
      || m_axis_tuser == KIND_HELD))
    else $error("bad event kind");

  // a fresh event follows an accepted tick
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready
      && (s_axis_tuser == OP_TICK)))
    else $error("event without a tick");

  // a pin change never produces an event
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PIN_CHANGE)
      && (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
    else $error("event from a pin change");

endmodule

bind button_debounce_hold_events bdhe_checker u_bdhe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
